// ----- hw/rtl/scd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the segment closest distance pipeline.
package scd_pkg;

	typedef logic signed [31:0]  coord_t;
	typedef logic signed [32:0]  diff_t;
	typedef logic signed [63:0]  dot_t;
	typedef logic signed [127:0] wide_t;
	typedef logic [16:0]         par_t;
	typedef logic [1:0]          mode_t;

	// how the second division result is used
	localparam mode_t MODE_MID  = 2'd0;
	localparam mode_t MODE_LOW  = 2'd1;
	localparam mode_t MODE_HIGH = 2'd2;

	localparam par_t PAR_ONE = 17'd65536;

	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned ROOT_W    = 34;
	localparam int unsigned SQ_W      = 68;

	typedef struct {
		coord_t a0 [3];
		coord_t b0 [3];
		diff_t  da [3];
		diff_t  db [3];
		dot_t   aa;
		dot_t   bb;
		dot_t   ab;
		dot_t   aw;
		dot_t   bw;
		mode_t  mode;
		par_t   kept;
	} side_t;

	typedef struct {
		coord_t pa [3];
		coord_t pb [3];
	} pts_t;

	function automatic logic [63:0] mag64(input dot_t x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

endpackage

// ----- hw/rtl/segment_closest_distance.sv -----
`timescale 1ns / 1ps
// Top level: closest points between two 3D segments and their distance.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  pair    | pair_valid, pair_stall | a_start/a_end/b_start/b_end x,y,z, Q16.16
//  res     | res_valid, res_stall   | distance, near_a x,y,z, near_b x,y,z
//
// One transaction per cycle enters while no result is stalled; each result passes
// through the two 17-stage quotient pipelines and the 35-stage square root.
// Reset clears only the valid bits; the block needs no clearing pass.
// A stalled result freezes the whole pipeline and raises pair_stall in the
// same cycle; bubbles are not squeezed out while frozen.
module segment_closest_distance (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  logic signed [31:0]   a_start_x,
	input  logic signed [31:0]   a_start_y,
	input  logic signed [31:0]   a_start_z,
	input  logic signed [31:0]   a_end_x,
	input  logic signed [31:0]   a_end_y,
	input  logic signed [31:0]   a_end_z,
	input  logic signed [31:0]   b_start_x,
	input  logic signed [31:0]   b_start_y,
	input  logic signed [31:0]   b_start_z,
	input  logic signed [31:0]   b_end_x,
	input  logic signed [31:0]   b_end_y,
	input  logic signed [31:0]   b_end_z,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [31:0]          distance,
	output logic signed [31:0]   near_a_x,
	output logic signed [31:0]   near_a_y,
	output logic signed [31:0]   near_a_z,
	output logic signed [31:0]   near_b_x,
	output logic signed [31:0]   near_b_y,
	output logic signed [31:0]   near_b_z
);

	logic en;

	scd_pkg::coord_t a_start [3];
	scd_pkg::coord_t a_end [3];
	scd_pkg::coord_t b_start [3];
	scd_pkg::coord_t b_end [3];

	logic           f_valid;
	scd_pkg::wide_t f_num, f_den;
	scd_pkg::side_t f_side;

	logic           d1_valid;
	scd_pkg::par_t  d1_q;
	scd_pkg::side_t d1_side;

	logic           v_t1, v_t2, v_t3;
	logic [63:0]    abm_w;
	logic [48:0]    plo_t1;
	logic [47:0]    phi_t1;
	logic           neg_t1;
	scd_pkg::par_t  sa_t1;
	scd_pkg::side_t side_t1, side_t2, side_t3;
	scd_pkg::side_t side_d2, side_d3;
	logic [127:0]   tmag_w;
	scd_pkg::wide_t tn_w, tn_t2, lim_w, num_t3, den_t3;
	scd_pkg::mode_t mode_w;
	scd_pkg::wide_t num_w, den_w;

	logic           d2_valid;
	scd_pkg::par_t  d2_q;
	scd_pkg::side_t d2_side;

	logic                       p_valid;
	logic [scd_pkg::SQ_W-1:0]   p_sq;
	scd_pkg::pts_t              p_pts;

	logic [scd_pkg::ROOT_W-1:0] root;
	scd_pkg::pts_t              r_pts;

	assign en         = !(res_valid && res_stall);
	assign pair_stall = !en;

	assign a_start[0] = a_start_x;
	assign a_start[1] = a_start_y;
	assign a_start[2] = a_start_z;
	assign a_end[0]   = a_end_x;
	assign a_end[1]   = a_end_y;
	assign a_end[2]   = a_end_z;
	assign b_start[0] = b_start_x;
	assign b_start[1] = b_start_y;
	assign b_start[2] = b_start_z;
	assign b_end[0]   = b_end_x;
	assign b_end[1]   = b_end_y;
	assign b_end[2]   = b_end_z;

	scd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pair_valid),
		.a_start   (a_start),
		.a_end     (a_end),
		.b_start   (b_start),
		.b_end     (b_end),
		.out_valid (f_valid),
		.num       (f_num),
		.den       (f_den),
		.side      (f_side)
	);

	scd_div u_div_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.num       (f_num),
		.den       (f_den),
		.side_in   (f_side),
		.out_valid (d1_valid),
		.q         (d1_q),
		.side_out  (d1_side)
	);

	// parameter on B from the first parameter on A, then pick the clamp case
	always_comb begin
		abm_w  = scd_pkg::mag64(d1_side.ab);
		tmag_w = (128'(phi_t1) << 32) + 128'(plo_t1);
		tn_w   = (neg_t1 ? -$signed(tmag_w) : $signed(tmag_w))
			+ (scd_pkg::wide_t'(side_t1.bw) <<< 16);
		lim_w  = scd_pkg::wide_t'(side_t2.bb) <<< 16;
		if (tn_t2[127]) begin
			mode_w = scd_pkg::MODE_LOW;
			num_w  = -scd_pkg::wide_t'(side_t2.aw);
			den_w  = scd_pkg::wide_t'(side_t2.aa);
		end else if (lim_w - tn_t2 < 0) begin
			mode_w = scd_pkg::MODE_HIGH;
			num_w  = scd_pkg::wide_t'(side_t2.ab) - scd_pkg::wide_t'(side_t2.aw);
			den_w  = scd_pkg::wide_t'(side_t2.aa);
		end else begin
			mode_w = scd_pkg::MODE_MID;
			num_w  = tn_t2;
			den_w  = lim_w;
		end
		side_d2      = side_t1;
		side_d2.kept = sa_t1;
		side_d3      = side_t2;
		side_d3.mode = mode_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
		end else if (en) begin
			v_t1 <= d1_valid;
			v_t2 <= v_t1;
			v_t3 <= v_t2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_t1  <= 49'(abm_w[31:0] * d1_q);
			phi_t1  <= 48'(abm_w[62:32] * d1_q);
			neg_t1  <= d1_side.ab[63];
			sa_t1   <= d1_q;
			side_t1 <= d1_side;

			tn_t2   <= tn_w;
			side_t2 <= side_d2;

			num_t3  <= num_w;
			den_t3  <= den_w;
			side_t3 <= side_d3;
		end
	end

	scd_div u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_t3),
		.num       (num_t3),
		.den       (den_t3),
		.side_in   (side_t3),
		.out_valid (d2_valid),
		.q         (d2_q),
		.side_out  (d2_side)
	);

	scd_point u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d2_valid),
		.q         (d2_q),
		.side_in   (d2_side),
		.out_valid (p_valid),
		.sq        (p_sq),
		.pts       (p_pts)
	);

	scd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (p_valid),
		.sq        (p_sq),
		.pts_in    (p_pts),
		.out_valid (res_valid),
		.root      (root),
		.pts_out   (r_pts)
	);

	// saturate roots above 32 bits
	assign distance = (root[scd_pkg::ROOT_W-1:32] != '0) ? 32'hFFFF_FFFF : root[31:0];
	assign near_a_x = r_pts.pa[0];
	assign near_a_y = r_pts.pa[1];
	assign near_a_z = r_pts.pa[2];
	assign near_b_x = r_pts.pb[0];
	assign near_b_y = r_pts.pb[1];
	assign near_b_z = r_pts.pb[2];

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_t3 && (side_t3.mode == scd_pkg::MODE_MID) |-> !num_t3[127] && (num_t3 <= den_t3))
		else $error("interior B parameter outside its segment");

endmodule

// ----- hw/rtl/scd_front.sv -----
`timescale 1ns / 1ps
// Front pipeline: direction vectors, dot products and the first quotient operands.
module scd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  scd_pkg::coord_t  a_start [3],
	input  scd_pkg::coord_t  a_end [3],
	input  scd_pkg::coord_t  b_start [3],
	input  scd_pkg::coord_t  b_end [3],
	output logic             out_valid,
	output scd_pkg::wide_t   num,
	output scd_pkg::wide_t   den,
	output scd_pkg::side_t   side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	scd_pkg::side_t side_d1;
	scd_pkg::side_t side_d3;
	scd_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	scd_pkg::diff_t w_d [3];

	logic signed [30:0] ha_s1 [3];
	logic signed [30:0] hb_s1 [3];
	logic signed [30:0] hw_s1 [3];

	logic signed [61:0] paa_s2 [3];
	logic signed [61:0] pbb_s2 [3];
	logic signed [61:0] pab_s2 [3];
	logic signed [61:0] paw_s2 [3];
	logic signed [61:0] pbw_s2 [3];

	scd_pkg::dot_t mx [4];
	scd_pkg::dot_t my [4];
	logic [63:0] ma [4];
	logic [63:0] mb [4];

	logic [63:0] ll_s4 [4];
	logic [63:0] lh_s4 [4];
	logic [63:0] hl_s4 [4];
	logic [63:0] hh_s4 [4];
	logic        neg_s4 [4];

	logic [127:0] mag_w [4];
	scd_pkg::wide_t prod_s5 [4];

	scd_pkg::wide_t num_s6, den_s6;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			side_d1.a0[k] = a_start[k];
			side_d1.b0[k] = b_start[k];
			side_d1.da[k] = scd_pkg::diff_t'(a_end[k]) - scd_pkg::diff_t'(a_start[k]);
			side_d1.db[k] = scd_pkg::diff_t'(b_end[k]) - scd_pkg::diff_t'(b_start[k]);
			w_d[k]        = scd_pkg::diff_t'(a_start[k]) - scd_pkg::diff_t'(b_start[k]);
		end
		side_d1.aa   = '0;
		side_d1.bb   = '0;
		side_d1.ab   = '0;
		side_d1.aw   = '0;
		side_d1.bw   = '0;
		side_d1.mode = scd_pkg::MODE_MID;
		side_d1.kept = '0;
	end

	always_comb begin
		side_d3    = side_s2;
		side_d3.aa = scd_pkg::dot_t'(paa_s2[0]) + paa_s2[1] + paa_s2[2];
		side_d3.bb = scd_pkg::dot_t'(pbb_s2[0]) + pbb_s2[1] + pbb_s2[2];
		side_d3.ab = scd_pkg::dot_t'(pab_s2[0]) + pab_s2[1] + pab_s2[2];
		side_d3.aw = scd_pkg::dot_t'(paw_s2[0]) + paw_s2[1] + paw_s2[2];
		side_d3.bw = scd_pkg::dot_t'(pbw_s2[0]) + pbw_s2[1] + pbw_s2[2];
	end

	always_comb begin
		mx[0] = side_s3.aa; my[0] = side_s3.bb;
		mx[1] = side_s3.ab; my[1] = side_s3.ab;
		mx[2] = side_s3.ab; my[2] = side_s3.bw;
		mx[3] = side_s3.aw; my[3] = side_s3.bb;
		for (int j = 0; j < 4; j++) begin
			ma[j] = scd_pkg::mag64(mx[j]);
			mb[j] = scd_pkg::mag64(my[j]);
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			mag_w[j] = (128'(hh_s4[j]) << 64) + (128'(lh_s4[j]) << 32)
				+ (128'(hl_s4[j]) << 32) + 128'(ll_s4[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d1;
			for (int k = 0; k < 3; k++) begin
				// floor shift right by two
				ha_s1[k] <= side_d1.da[k][32:2];
				hb_s1[k] <= side_d1.db[k][32:2];
				hw_s1[k] <= w_d[k][32:2];
			end

			side_s2 <= side_s1;
			for (int k = 0; k < 3; k++) begin
				paa_s2[k] <= ha_s1[k] * ha_s1[k];
				pbb_s2[k] <= hb_s1[k] * hb_s1[k];
				pab_s2[k] <= ha_s1[k] * hb_s1[k];
				paw_s2[k] <= ha_s1[k] * hw_s1[k];
				pbw_s2[k] <= hb_s1[k] * hw_s1[k];
			end

			side_s3 <= side_d3;

			side_s4 <= side_s3;
			for (int j = 0; j < 4; j++) begin
				ll_s4[j]  <= 64'(ma[j][31:0] * mb[j][31:0]);
				lh_s4[j]  <= 64'(ma[j][31:0] * mb[j][62:32]);
				hl_s4[j]  <= 64'(ma[j][62:32] * mb[j][31:0]);
				hh_s4[j]  <= 64'(ma[j][62:32] * mb[j][62:32]);
				neg_s4[j] <= mx[j][63] ^ my[j][63];
			end

			side_s5 <= side_s4;
			for (int j = 0; j < 4; j++) begin
				prod_s5[j] <= neg_s4[j] ? -$signed(mag_w[j]) : $signed(mag_w[j]);
			end

			side_s6 <= side_s5;
			den_s6  <= prod_s5[0] - prod_s5[1];
			num_s6  <= prod_s5[2] - prod_s5[3];
		end
	end

	assign out_valid = v_s6;
	assign num       = num_s6;
	assign den       = den_s6;
	assign side      = side_s6;

endmodule

// ----- hw/rtl/scd_div.sv -----
`timescale 1ns / 1ps
// Pipelined clamped Q1.16 quotient, one quotient bit per stage.
module scd_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  scd_pkg::wide_t  num,
	input  scd_pkg::wide_t  den,
	input  scd_pkg::side_t  side_in,
	output logic            out_valid,
	output scd_pkg::par_t   q,
	output scd_pkg::side_t  side_out
);

	localparam int unsigned N = scd_pkg::DIV_STEPS;

	logic           v_s    [N+1];
	logic [127:0]   rem_s  [N+1];
	logic [127:0]   dd_s   [N+1];
	logic [N-1:0]   qb_s   [N+1];
	logic           zero_s [N+1];
	logic           one_s  [N+1];
	scd_pkg::side_t side_s [N+1];

	logic [128:0] r2_w [N];
	logic         ge_w [N];
	logic         zero_d, one_d;

	always_comb begin
		zero_d = den[127] || (den == '0) || num[127] || (num == '0);
		one_d  = !zero_d && (num >= den);
		for (int j = 0; j < N; j++) begin
			r2_w[j] = {rem_s[j], 1'b0};
			ge_w[j] = r2_w[j] >= {1'b0, dd_s[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= N; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int j = 0; j < N; j++) v_s[j+1] <= v_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			dd_s[0]   <= den;
			qb_s[0]   <= '0;
			zero_s[0] <= zero_d;
			one_s[0]  <= one_d;
			side_s[0] <= side_in;
			for (int j = 0; j < N; j++) begin
				rem_s[j+1]  <= ge_w[j] ? 128'(r2_w[j] - {1'b0, dd_s[j]}) : r2_w[j][127:0];
				dd_s[j+1]   <= dd_s[j];
				qb_s[j+1]   <= {qb_s[j][N-2:0], ge_w[j]};
				zero_s[j+1] <= zero_s[j];
				one_s[j+1]  <= one_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[N];
	assign q         = one_s[N] ? scd_pkg::PAR_ONE :
		(zero_s[N] ? '0 : scd_pkg::par_t'(qb_s[N]));
	assign side_out  = side_s[N];

	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> q <= scd_pkg::PAR_ONE)
		else $error("quotient above one");

endmodule

// ----- hw/rtl/scd_point.sv -----
`timescale 1ns / 1ps
// Closest points on both segments and the squared distance between them.
module scd_point (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  scd_pkg::par_t               q,
	input  scd_pkg::side_t              side_in,
	output logic                        out_valid,
	output logic [scd_pkg::SQ_W-1:0]    sq,
	output scd_pkg::pts_t               pts
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	scd_pkg::par_t sa_w, tb_w;

	logic signed [50:0] pra_s1 [3];
	logic signed [50:0] prb_s1 [3];
	scd_pkg::coord_t    a0_s1 [3];
	scd_pkg::coord_t    b0_s1 [3];

	logic signed [50:0] rna_w [3];
	logic signed [50:0] rnb_w [3];

	scd_pkg::pts_t pts_s2, pts_s3, pts_s4, pts_s5;
	scd_pkg::diff_t e_s3 [3];
	logic [32:0] me_w [3];
	logic [65:0] esq_s4 [3];
	logic [scd_pkg::SQ_W-1:0] sq_s5;

	always_comb begin
		case (side_in.mode)
			scd_pkg::MODE_MID: begin
				sa_w = side_in.kept;
				tb_w = q;
			end
			scd_pkg::MODE_LOW: begin
				sa_w = q;
				tb_w = '0;
			end
			scd_pkg::MODE_HIGH: begin
				sa_w = q;
				tb_w = scd_pkg::PAR_ONE;
			end
			default: begin
				sa_w = q;
				tb_w = '0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rna_w[k] = pra_s1[k] + 51'sd32768;
			rnb_w[k] = prb_s1[k] + 51'sd32768;
			me_w[k]  = e_s3[k][32] ? 33'(-e_s3[k]) : 33'(e_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pra_s1[k] <= side_in.da[k] * $signed({1'b0, sa_w});
				prb_s1[k] <= side_in.db[k] * $signed({1'b0, tb_w});
				a0_s1[k]  <= side_in.a0[k];
				b0_s1[k]  <= side_in.b0[k];
			end

			// the point stays on its segment, so the low 32 bits are exact
			for (int k = 0; k < 3; k++) begin
				pts_s2.pa[k] <= a0_s1[k] + scd_pkg::coord_t'(rna_w[k][47:16]);
				pts_s2.pb[k] <= b0_s1[k] + scd_pkg::coord_t'(rnb_w[k][47:16]);
			end

			pts_s3 <= pts_s2;
			for (int k = 0; k < 3; k++) begin
				e_s3[k] <= scd_pkg::diff_t'(pts_s2.pa[k]) - scd_pkg::diff_t'(pts_s2.pb[k]);
			end

			pts_s4 <= pts_s3;
			for (int k = 0; k < 3; k++) begin
				esq_s4[k] <= 66'(me_w[k] * me_w[k]);
			end

			pts_s5 <= pts_s4;
			sq_s5  <= scd_pkg::SQ_W'(esq_s4[0]) + scd_pkg::SQ_W'(esq_s4[1])
				+ scd_pkg::SQ_W'(esq_s4[2]);
		end
	end

	assign out_valid = v_s5;
	assign sq        = sq_s5;
	assign pts       = pts_s5;

endmodule

// ----- hw/rtl/scd_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module scd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [scd_pkg::SQ_W-1:0]      sq,
	input  scd_pkg::pts_t                 pts_in,
	output logic                          out_valid,
	output logic [scd_pkg::ROOT_W-1:0]    root,
	output scd_pkg::pts_t                 pts_out
);

	localparam int unsigned N  = scd_pkg::ROOT_W;
	localparam int unsigned RW = scd_pkg::SQ_W + 2;

	logic          v_s    [N+1];
	logic [RW-1:0] rem_s  [N+1];
	logic [N-1:0]  root_s [N+1];
	scd_pkg::pts_t pts_s  [N+1];

	logic [RW-1:0] inc_w [N];
	logic          take_w [N];

	// (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
	always_comb begin
		for (int i = 0; i < N; i++) begin
			inc_w[i]  = (RW'(root_s[i]) << (N - i)) + (RW'(1) << (2 * (N - 1 - i)));
			take_w[i] = inc_w[i] <= rem_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 0; i < N; i++) v_s[i+1] <= v_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'(sq);
			root_s[0] <= '0;
			pts_s[0]  <= pts_in;
			for (int i = 0; i < N; i++) begin
				rem_s[i+1]  <= take_w[i] ? rem_s[i] - inc_w[i] : rem_s[i];
				root_s[i+1] <= take_w[i] ? (root_s[i] | (N'(1) << (N - 1 - i))) : root_s[i];
				pts_s[i+1]  <= pts_s[i];
			end
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
	assign pts_out   = pts_s[N];

	// floor root leaves a remainder of at most 2r
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_s[N] <= RW'({root_s[N], 1'b0}))
		else $error("root remainder too large");

endmodule
